// ===== rtl/core/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg: shared types and codes for the line stepper
// Request codes and the per-line direction flags passed between the setup
// logic, the step logic and the top level.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    typedef struct packed {
        logic x_is_major;
        logic minor_goes_down;
        logic tie_steps_major_only;
    } line_ctrl_t;

endpackage

// ===== rtl/core/bls_setup.sv =====
// ----------------------------------------------------------------------------
// bls_setup: line setup from two endpoints
// Orders the endpoints left to right, measures the spans, picks the major
// axis and forms the initial decision term.
// ----------------------------------------------------------------------------
module bls_setup #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]   first_x,
    input  logic [COORD_BITS-1:0]   first_y,
    input  logic [COORD_BITS-1:0]   second_x,
    input  logic [COORD_BITS-1:0]   second_y,
    output logic [COORD_BITS-1:0]   start_col,
    output logic [COORD_BITS-1:0]   start_row,
    output logic [COORD_BITS-1:0]   major_end,
    output logic [COORD_BITS-1:0]   major_span,
    output logic [COORD_BITS-1:0]   minor_span,
    output logic [COORD_BITS+2:0]   decision_term,
    output bls_pkg::line_ctrl_t     ctrl,
    output logic                    single_point
);

    logic                  swap;
    logic [COORD_BITS-1:0] end_col;
    logic [COORD_BITS-1:0] end_row;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  down;
    logic                  x_major;

    // start from the left end, or the lower-row end for vertical lines
    assign swap      = (first_x > second_x) || ((first_x == second_x) && (first_y > second_y));
    assign start_col = swap ? second_x : first_x;
    assign start_row = swap ? second_y : first_y;
    assign end_col   = swap ? first_x : second_x;
    assign end_row   = swap ? first_y : second_y;

    assign dx      = end_col - start_col;
    assign down    = end_row < start_row;
    assign dy      = down ? (start_row - end_row) : (end_row - start_row);
    assign x_major = dx >= dy;

    assign major_span = x_major ? dx : dy;
    assign minor_span = x_major ? dy : dx;
    assign major_end  = x_major ? end_col : end_row;

    assign decision_term = {2'b00, minor_span, 1'b0} - {3'b000, major_span};

    assign ctrl.x_is_major           = x_major;
    assign ctrl.minor_goes_down      = down;
    assign ctrl.tie_steps_major_only = !x_major && down;

    assign single_point = (major_span == '0);

endmodule

// ===== rtl/core/bls_step.sv =====
// ----------------------------------------------------------------------------
// bls_step: one Bresenham advance
// Steps the major axis, steps the minor axis when the decision term allows,
// updates the decision term and flags the far endpoint.
// ----------------------------------------------------------------------------
module bls_step #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]   cur_col,
    input  logic [COORD_BITS-1:0]   cur_row,
    input  logic [COORD_BITS-1:0]   major_end,
    input  logic [COORD_BITS-1:0]   major_span,
    input  logic [COORD_BITS-1:0]   minor_span,
    input  logic [COORD_BITS+2:0]   decision_term,
    input  bls_pkg::line_ctrl_t     ctrl,
    output logic [COORD_BITS-1:0]   next_col,
    output logic [COORD_BITS-1:0]   next_row,
    output logic [COORD_BITS+2:0]   next_decision,
    output logic                    last
);

    localparam int DW = COORD_BITS + 3;
    localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

    logic                  neg;
    logic                  minor_step;
    logic [COORD_BITS-1:0] col_inc;
    logic [COORD_BITS-1:0] row_stepped;
    logic [DW-1:0]         two_minor;
    logic [DW-1:0]         two_diff;

    assign neg        = decision_term[DW-1];
    // steep descending lines treat a zero decision as major-only
    assign minor_step = ctrl.tie_steps_major_only ? (!neg && (decision_term != '0)) : !neg;

    assign col_inc     = cur_col + ONE;
    assign row_stepped = ctrl.minor_goes_down ? (cur_row - ONE) : (cur_row + ONE);

    always_comb begin
        if (ctrl.x_is_major) begin
            next_col = col_inc;
            next_row = minor_step ? row_stepped : cur_row;
        end else begin
            next_row = row_stepped;
            next_col = minor_step ? col_inc : cur_col;
        end
    end

    assign two_minor     = {2'b00, minor_span, 1'b0};
    assign two_diff      = two_minor - {2'b00, major_span, 1'b0};
    assign next_decision = decision_term + (minor_step ? two_diff : two_minor);

    assign last = ctrl.x_is_major ? (next_col == major_end) : (next_row == major_end);

endmodule

// ===== rtl/core/bresenham_line_stepper.sv =====
// an accepted request's pixel is registered and shown on the m_ side in the cycle after
// throughput: one request per cycle unless m_ready stalls; the result register frees as it is taken
// s_ready drops only while a pixel waits in the result register and m_ready is low
// reset: synchronous active-low aresetn clears the line state (column marked
// as major axis) and empties the result register
// ----------------------------------------------------------------------------
// bresenham_line_stepper: integer line rasterizer for all octants
// A start transaction loads two endpoints and returns the first pixel; each
// advance transaction returns the next pixel and flags the far endpoint.
// ----------------------------------------------------------------------------
module bresenham_line_stepper #(
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [COORD_BITS-1:0] s_first_x,
    input  logic [COORD_BITS-1:0] s_first_y,
    input  logic [COORD_BITS-1:0] s_second_x,
    input  logic [COORD_BITS-1:0] s_second_y,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic                  m_pixel_valid,
    output logic                  m_last_pixel
);

    localparam int DW = COORD_BITS + 3;

    // line state
    logic                  line_active_reg, line_active_next;
    logic [COORD_BITS-1:0] cur_col_reg, cur_col_next;
    logic [COORD_BITS-1:0] cur_row_reg, cur_row_next;
    logic [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic [COORD_BITS-1:0] major_span_reg, major_span_next;
    logic [COORD_BITS-1:0] minor_span_reg, minor_span_next;
    logic [DW-1:0]         decision_reg, decision_next;
    bls_pkg::line_ctrl_t   ctrl_reg, ctrl_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;
    logic                  pvalid_reg, pvalid_next;
    logic                  plast_reg, plast_next;

    // setup outputs
    logic [COORD_BITS-1:0] su_col, su_row, su_major_end, su_major_span, su_minor_span;
    logic [DW-1:0]         su_decision;
    bls_pkg::line_ctrl_t   su_ctrl;
    logic                  su_single;

    // step outputs
    logic [COORD_BITS-1:0] st_col, st_row;
    logic [DW-1:0]         st_decision;
    logic                  st_last;

    logic                  in_xfer;

    bls_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .first_x       (s_first_x),
        .first_y       (s_first_y),
        .second_x      (s_second_x),
        .second_y      (s_second_y),
        .start_col     (su_col),
        .start_row     (su_row),
        .major_end     (su_major_end),
        .major_span    (su_major_span),
        .minor_span    (su_minor_span),
        .decision_term (su_decision),
        .ctrl          (su_ctrl),
        .single_point  (su_single)
    );

    bls_step #(.COORD_BITS(COORD_BITS)) u_step (
        .cur_col       (cur_col_reg),
        .cur_row       (cur_row_reg),
        .major_end     (major_end_reg),
        .major_span    (major_span_reg),
        .minor_span    (minor_span_reg),
        .decision_term (decision_reg),
        .ctrl          (ctrl_reg),
        .next_col      (st_col),
        .next_row      (st_row),
        .next_decision (st_decision),
        .last          (st_last)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        line_active_next = line_active_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        major_end_next   = major_end_reg;
        major_span_next  = major_span_reg;
        minor_span_next  = minor_span_reg;
        decision_next    = decision_reg;
        ctrl_next        = ctrl_reg;

        m_valid_next = m_valid_reg && !m_ready;
        px_next      = px_reg;
        py_next      = py_reg;
        pvalid_next  = pvalid_reg;
        plast_next   = plast_reg;

        if (in_xfer) begin
            m_valid_next = 1'b1;
            if (s_req_type == bls_pkg::REQ_START) begin
                cur_col_next     = su_col;
                cur_row_next     = su_row;
                major_end_next   = su_major_end;
                major_span_next  = su_major_span;
                minor_span_next  = su_minor_span;
                decision_next    = su_decision;
                ctrl_next        = su_ctrl;
                line_active_next = !su_single;
                px_next          = su_col;
                py_next          = su_row;
                pvalid_next      = 1'b1;
                plast_next       = su_single;
            end else if (line_active_reg) begin
                cur_col_next     = st_col;
                cur_row_next     = st_row;
                decision_next    = st_decision;
                line_active_next = !st_last;
                px_next          = st_col;
                py_next          = st_row;
                pvalid_next      = 1'b1;
                plast_next       = st_last;
            end else begin
                // advance with no line: empty pixel, state untouched
                px_next     = '0;
                py_next     = '0;
                pvalid_next = 1'b0;
                plast_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            major_end_reg   <= '0;
            major_span_reg  <= '0;
            minor_span_reg  <= '0;
            decision_reg    <= '0;
            ctrl_reg        <= '{x_is_major: 1'b1, minor_goes_down: 1'b0,
                                 tie_steps_major_only: 1'b0};
            m_valid_reg     <= 1'b0;
            px_reg          <= '0;
            py_reg          <= '0;
            pvalid_reg      <= 1'b0;
            plast_reg       <= 1'b0;
        end else begin
            line_active_reg <= line_active_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            major_end_reg   <= major_end_next;
            major_span_reg  <= major_span_next;
            minor_span_reg  <= minor_span_next;
            decision_reg    <= decision_next;
            ctrl_reg        <= ctrl_next;
            m_valid_reg     <= m_valid_next;
            px_reg          <= px_next;
            py_reg          <= py_next;
            pvalid_reg      <= pvalid_next;
            plast_reg       <= plast_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_valid = pvalid_reg;
    assign m_last_pixel  = plast_reg;

    // an empty result carries all-zero fields
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pixel_valid) |->
            (m_pixel_x == '0 && m_pixel_y == '0 && !m_last_pixel))
        else $error("empty result with nonzero fields");

    // advancing with no line gives an empty result
    a_idle_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_req_type == bls_pkg::REQ_ADVANCE && !line_active_reg) |=>
            (m_valid && !m_pixel_valid && !line_active_reg))
        else $error("advance without a line produced a pixel");

    // the line ends exactly when its last pixel is produced
    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && pvalid_next) |=> (line_active_reg == !m_last_pixel))
        else $error("line activity disagrees with last pixel flag");

    // a steep line always carries a row-major tie rule consistent with direction
    a_tie_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        line_active_reg |->
            (ctrl_reg.tie_steps_major_only ==
             (!ctrl_reg.x_is_major && ctrl_reg.minor_goes_down)))
        else $error("tie rule inconsistent with line direction");

endmodule

// ===== verif/bresenham_line_checker.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_checker: pixel predictor and scoreboard for the line stepper
// Watches both channels, steps its own copy of the line state on each request
// transaction and compares every returned pixel field by field in order.
// ----------------------------------------------------------------------------
module bresenham_line_checker #(
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [COORD_BITS-1:0] s_first_x,
    input  logic [COORD_BITS-1:0] s_first_y,
    input  logic [COORD_BITS-1:0] s_second_x,
    input  logic [COORD_BITS-1:0] s_second_y,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [COORD_BITS-1:0] m_pixel_x,
    input  logic [COORD_BITS-1:0] m_pixel_y,
    input  logic                  m_pixel_valid,
    input  logic                  m_last_pixel,

    output int                    mismatch_count,
    output int                    pixels_pending,
    output int                    start_count,
    output int                    advance_count,
    output int                    lines_finished
);

    localparam int FIFO_DEPTH = 16;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  on;
        logic                  last;
    } pixel_t;

    // expected pixels in transaction order
    pixel_t     pixel_fifo[FIFO_DEPTH];
    logic [3:0] fifo_wr;
    logic [3:0] fifo_rd;
    int         fifo_count;

    // line state mirrored from the stepper
    logic                  line_busy;
    logic [COORD_BITS-1:0] col_now;
    logic [COORD_BITS-1:0] row_now;
    logic [COORD_BITS-1:0] major_stop;
    logic [COORD_BITS-1:0] major_len;
    logic [COORD_BITS-1:0] minor_len;
    int                    err_term;
    bls_pkg::line_ctrl_t   dir;

    function automatic pixel_t plot_next(input logic req,
                                         input logic [COORD_BITS-1:0] ax,
                                         input logic [COORD_BITS-1:0] ay,
                                         input logic [COORD_BITS-1:0] bx,
                                         input logic [COORD_BITS-1:0] by);
        logic [COORD_BITS-1:0] sx, sy, ex, ey, dx, dy, major_pos;
        logic                  do_minor;
        pixel_t                px;
        px = '0;
        if (req == bls_pkg::REQ_START) begin
            // always walk from the left end, lower row first on verticals
            if (ax < bx || (ax == bx && ay <= by)) begin
                sx = ax; sy = ay; ex = bx; ey = by;
            end else begin
                sx = bx; sy = by; ex = ax; ey = ay;
            end
            dx = ex - sx;
            dir.minor_goes_down = ey < sy;
            dy = dir.minor_goes_down ? sy - ey : ey - sy;
            dir.x_is_major = dx >= dy;
            dir.tie_steps_major_only = !dir.x_is_major && dir.minor_goes_down;
            major_len  = dir.x_is_major ? dx : dy;
            minor_len  = dir.x_is_major ? dy : dx;
            major_stop = dir.x_is_major ? ex : ey;
            err_term   = 2 * int'(minor_len) - int'(major_len);
            col_now    = sx;
            row_now    = sy;
            line_busy  = major_len != '0;
            px.x    = col_now;
            px.y    = row_now;
            px.on   = 1'b1;
            px.last = major_len == '0;
        end else if (line_busy) begin
            do_minor = dir.tie_steps_major_only ? (err_term > 0) : (err_term >= 0);
            if (dir.x_is_major) begin
                col_now = col_now + 1'b1;
                if (do_minor)
                    row_now = dir.minor_goes_down ? row_now - 1'b1 : row_now + 1'b1;
                major_pos = col_now;
            end else begin
                row_now = dir.minor_goes_down ? row_now - 1'b1 : row_now + 1'b1;
                if (do_minor)
                    col_now = col_now + 1'b1;
                major_pos = row_now;
            end
            if (do_minor)
                err_term += 2 * (int'(minor_len) - int'(major_len));
            else
                err_term += 2 * int'(minor_len);
            px.x    = col_now;
            px.y    = row_now;
            px.on   = 1'b1;
            px.last = major_pos == major_stop;
            if (px.last)
                line_busy = 1'b0;
        end
        return px;
    endfunction

    // sampled on the falling edge: everything here is stable until the next rising edge
    always @(negedge aclk) begin
        pixel_t want;
        pixel_t predicted;
        if (!aresetn) begin
            line_busy  = 1'b0;
            col_now    = '0;
            row_now    = '0;
            major_stop = '0;
            major_len  = '0;
            minor_len  = '0;
            err_term   = 0;
            dir.x_is_major           = 1'b1;
            dir.minor_goes_down      = 1'b0;
            dir.tie_steps_major_only = 1'b0;
            fifo_wr        = '0;
            fifo_rd        = '0;
            fifo_count     = 0;
            mismatch_count = 0;
            start_count    = 0;
            advance_count  = 0;
            lines_finished = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (fifo_count == 0) begin
                    $error("pixel transaction with nothing pending: x=%0d y=%0d",
                           m_pixel_x, m_pixel_y);
                    mismatch_count++;
                end else begin
                    want = pixel_fifo[fifo_rd];
                    fifo_rd = fifo_rd + 4'd1;
                    fifo_count--;
                    if (m_pixel_x !== want.x) begin
                        $error("pixel_x: expected %0d, actual %0d", want.x, m_pixel_x);
                        mismatch_count++;
                    end
                    if (m_pixel_y !== want.y) begin
                        $error("pixel_y: expected %0d, actual %0d", want.y, m_pixel_y);
                        mismatch_count++;
                    end
                    if (m_pixel_valid !== want.on) begin
                        $error("pixel_valid: expected %0b, actual %0b",
                               want.on, m_pixel_valid);
                        mismatch_count++;
                    end
                    if (m_last_pixel !== want.last) begin
                        $error("last_pixel: expected %0b, actual %0b",
                               want.last, m_last_pixel);
                        mismatch_count++;
                    end
                    if (want.last)
                        lines_finished++;
                end
            end
            if (s_valid && s_ready) begin
                predicted = plot_next(s_req_type, s_first_x, s_first_y,
                                      s_second_x, s_second_y);
                if (fifo_count == FIFO_DEPTH) begin
                    $error("more request transactions in flight than expected");
                    mismatch_count++;
                end else begin
                    pixel_fifo[fifo_wr] = predicted;
                    fifo_wr = fifo_wr + 4'd1;
                    fifo_count++;
                end
                if (s_req_type == bls_pkg::REQ_START)
                    start_count++;
                else
                    advance_count++;
            end
        end
        pixels_pending = fifo_count;
    end

endmodule

// ===== verif/bresenham_line_stepper_tb.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_stepper_tb: randomized line drawing test for the stepper
// Directed endpoint and octant cases, then random lines walked to their end,
// cut short or overrun, under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_tb;

    localparam int COORD_BITS  = 10;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int ITEM_TARGET = 950;
    localparam int CYCLE_LIMIT = 200000;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic                  s_req_type = bls_pkg::REQ_START;
    logic [COORD_BITS-1:0] s_first_x  = '0;
    logic [COORD_BITS-1:0] s_first_y  = '0;
    logic [COORD_BITS-1:0] s_second_x = '0;
    logic [COORD_BITS-1:0] s_second_y = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [COORD_BITS-1:0] m_pixel_x;
    logic [COORD_BITS-1:0] m_pixel_y;
    logic                  m_pixel_valid;
    logic                  m_last_pixel;

    int mismatch_count;
    int pixels_pending;
    int start_count;
    int advance_count;
    int lines_finished;

    int items_sent    = 0;
    int send_idle_pct = 22;
    int recv_idle_pct = 46;
    int cycle_count   = 0;

    bresenham_line_stepper #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_first_x     (s_first_x),
        .s_first_y     (s_first_y),
        .s_second_x    (s_second_x),
        .s_second_y    (s_second_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_valid (m_pixel_valid),
        .m_last_pixel  (m_last_pixel)
    );

    bresenham_line_checker #(
        .COORD_BITS (COORD_BITS)
    ) line_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_first_x      (s_first_x),
        .s_first_y      (s_first_y),
        .s_second_x     (s_second_x),
        .s_second_y     (s_second_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_valid  (m_pixel_valid),
        .m_last_pixel   (m_last_pixel),
        .mismatch_count (mismatch_count),
        .pixels_pending (pixels_pending),
        .start_count    (start_count),
        .advance_count  (advance_count),
        .lines_finished (lines_finished)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still pending",
                     cycle_count, pixels_pending);
            $display("bresenham_line_stepper_tb failed");
            $finish;
        end
    end

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_req(input logic rt,
                            input int ax,
                            input int ay,
                            input int bx,
                            input int by);
        logic taken;
        if (items_sent < 330) begin
            send_idle_pct = 22; recv_idle_pct = 46;
        end else if (items_sent < 660) begin
            send_idle_pct = 46; recv_idle_pct = 22;
        end else begin
            send_idle_pct = 0;  recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= rt;
        s_first_x  <= COORD_BITS'(ax);
        s_first_y  <= COORD_BITS'(ay);
        s_second_x <= COORD_BITS'(bx);
        s_second_y <= COORD_BITS'(by);
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        items_sent++;
    endtask

    // advance payloads carry random endpoints that the block must ignore
    task automatic advance_line(input int count);
        for (int i = 0; i < count && items_sent < ITEM_TARGET; i++)
            send_req(bls_pkg::REQ_ADVANCE, $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX));
    endtask

    function automatic int clamp_coord(input int v);
        return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
    endfunction

    task automatic random_line();
        int span, ddx, ddy, ax, ay, bx, by, dxa, dya, major, pick, steps;
        pick = $urandom_range(99);
        if (pick < 85)
            span = $urandom_range(10);
        else if (pick < 98)
            span = $urandom_range(48, 11);
        else
            span = $urandom_range(COORD_MAX, 49);
        ax  = $urandom_range(COORD_MAX);
        ay  = $urandom_range(COORD_MAX);
        ddx = $urandom_range(span);
        ddy = $urandom_range(span);
        if ($urandom_range(1))
            ddx = span;
        else
            ddy = span;
        if ($urandom_range(1))
            ddx = -ddx;
        if ($urandom_range(1))
            ddy = -ddy;
        bx    = clamp_coord(ax + ddx);
        by    = clamp_coord(ay + ddy);
        dxa   = bx > ax ? bx - ax : ax - bx;
        dya   = by > ay ? by - ay : ay - by;
        major = dxa > dya ? dxa : dya;
        // mostly complete lines, some dropped early by the next start, some overrun
        pick = $urandom_range(99);
        if (pick < 8)
            steps = $urandom_range(major);
        else if (pick < 16)
            steps = major + $urandom_range(3, 1);
        else
            steps = major;
        send_req(bls_pkg::REQ_START, ax, ay, bx, by);
        advance_line(steps);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        advance_line(1);                                       // no line active yet
        send_req(bls_pkg::REQ_START, 5, 5, 5, 5);              // single point
        advance_line(1);
        send_req(bls_pkg::REQ_START, 0, 0, COORD_MAX, COORD_MAX);
        advance_line(2);
        send_req(bls_pkg::REQ_START, COORD_MAX, 0, 0, COORD_MAX); // drops the active line
        advance_line(1);
        send_req(bls_pkg::REQ_START, 10, 7, 6, 7);             // horizontal, right to left
        advance_line(4);
        send_req(bls_pkg::REQ_START, 3, 9, 3, 6);              // vertical, given top down
        advance_line(4);
        send_req(bls_pkg::REQ_START, 0, 2, 1, 0);              // steep descending with a tie
        advance_line(2);

        while (items_sent < ITEM_TARGET)
            random_line();
        s_valid <= 1'b0;

        // let the checker record the final transaction before draining
        @(negedge aclk);
        while (pixels_pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("%0d request transactions: %0d line starts, %0d advances",
                 items_sent, start_count, advance_count);
        $display("%0d lines reached their far endpoint across three stall mixes",
                 lines_finished);
        if (mismatch_count == 0)
            $display("bresenham_line_stepper_tb passed");
        else
            $display("bresenham_line_stepper_tb failed");
        $finish;
    end

endmodule
